// ----- sv/io_stream_sequentiality_classifier_defines.svh -----
// Assertion macros used by the sqc_engine RTL.
`ifndef IO_STREAM_SEQUENTIALITY_CLASSIFIER_DEFINES_SVH
`define IO_STREAM_SEQUENTIALITY_CLASSIFIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, cond, prop)
`define ASSERT_NEXT(name, clk, rst, cond, prop)
`endif
`endif

// ----- sv/sqc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sqc_pkg;

   localparam int PROCESS_ENTRIES = 1024;
   localparam int STREAM_ENTRIES  = 4096;
   localparam int COUNTER_BITS    = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int NUM_COUNTERS    = 8;
   localparam int NO_SEEK_CODE    = 29;
   localparam logic [63:0] NO_SEEK_RET = 64'd0 - 64'(NO_SEEK_CODE);

   localparam logic [2:0] OP_RD     = 3'd0;
   localparam logic [2:0] OP_WR     = 3'd1;
   localparam logic [2:0] OP_POS_RD = 3'd2;
   localparam logic [2:0] OP_POS_WR = 3'd3;
   localparam logic [2:0] OP_OPEN   = 3'd4;
   localparam logic [2:0] OP_SEEK   = 3'd5;
   localparam logic [2:0] OP_SHUT   = 3'd6;

   localparam logic [2:0] OUT_SEQ   = 3'd0;
   localparam logic [2:0] OUT_RAND  = 3'd1;
   localparam logic [2:0] OUT_UNCLS = 3'd2;
   localparam logic [2:0] OUT_BOOK  = 3'd3;
   localparam logic [2:0] OUT_DROP  = 3'd4;

   localparam logic [2:0] CNT_RTOT = 3'd0;
   localparam logic [2:0] CNT_WTOT = 3'd1;
   localparam logic [2:0] CNT_SR   = 3'd2;
   localparam logic [2:0] CNT_RR   = 3'd3;
   localparam logic [2:0] CNT_SW   = 3'd4;
   localparam logic [2:0] CNT_RW   = 3'd5;
   localparam logic [2:0] CNT_UR   = 3'd6;
   localparam logic [2:0] CNT_UW   = 3'd7;

   localparam int F_LAST   = 0;
   localparam int F_CURSOR = 1;
   localparam int F_NOSEEK = 2;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] pid;
      logic [31:0] key_lo;
      logic [63:0] pos;
      logic [63:0] ret;
      logic        need_stream;
      logic        may_create;
   } cmd_type;

   typedef struct packed {
      logic        push;
      cmd_type     cmd;
   } push_type;

   typedef struct packed {
      logic        used;
      logic [63:0] key;
      logic [63:0] end_pos;
      logic [63:0] cursor;
      logic [2:0]  flags;
   } stream_type;

endpackage
`default_nettype wire

// ----- sv/sqc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sqc_front (
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [191:0]     req_tdata,  // process_id, file_handle, explicit_offset, call_result
   input  wire logic [2:0]       req_tuser,  // req_type
   input  wire logic             full_i,
   output sqc_pkg::push_type     push_o
);

   logic [2:0]  op;
   logic [63:0] ret;

   assign op  = req_tuser;
   assign ret = req_tdata[191:128];
   assign req_tready = !full_i;

   always_comb begin
      push_o.push       = req_tvalid && !full_i;
      push_o.cmd.op     = op;
      push_o.cmd.pid    = req_tdata[31:0];
      push_o.cmd.key_lo = (op == sqc_pkg::OP_OPEN) ? ret[31:0] : req_tdata[63:32];
      push_o.cmd.pos    = req_tdata[127:64];
      push_o.cmd.ret    = ret;
      push_o.cmd.need_stream = (op == sqc_pkg::OP_RD) || (op == sqc_pkg::OP_WR) ||
         (op == sqc_pkg::OP_POS_RD) || (op == sqc_pkg::OP_POS_WR) ||
         (op == sqc_pkg::OP_SEEK) || ((op == sqc_pkg::OP_OPEN) && !ret[63]) ||
         ((op == sqc_pkg::OP_SHUT) && (ret == 64'd0));
      push_o.cmd.may_create = (op != sqc_pkg::OP_SHUT);
   end

endmodule
`default_nettype wire

// ----- sv/sqc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sqc_queue #(
   parameter int DEPTH = sqc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sqc_pkg::push_type push_i,
   output logic                   full_o,
   output logic                   valid_o,
   output sqc_pkg::cmd_type       cmd_o,
   input  wire logic              pop_i
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   sqc_pkg::cmd_type slot_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNW-1:0] count_ff, count_in;

   assign full_o  = (count_ff == CNW'(DEPTH));
   assign valid_o = (count_ff != '0);
   assign cmd_o   = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push_i.push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + CNW'(push_i.push) - CNW'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i.push) begin
         slot_ff[wr_ff] <= push_i.cmd;
      end
   end

endmodule
`default_nettype wire

// ----- sv/sqc_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "io_stream_sequentiality_classifier_defines.svh"
module sqc_engine #(
   parameter int PROCESS_ENTRIES = sqc_pkg::PROCESS_ENTRIES,
   parameter int STREAM_ENTRIES  = sqc_pkg::STREAM_ENTRIES,
   parameter int COUNTER_BITS    = sqc_pkg::COUNTER_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid_i,
   input  wire sqc_pkg::cmd_type cmd_i,
   output logic                  cmd_pop_o,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [255:0]          rsp_tdata,  // read_total, write_total, seq_read_count,
                                             // rand_read_count, seq_write_count,
                                             // rand_write_count, uncls_read_count,
                                             // uncls_write_count
   output logic [2:0]            rsp_tuser   // outcome
);

   localparam int PIW = (PROCESS_ENTRIES > 1) ? $clog2(PROCESS_ENTRIES) : 1;
   localparam int PFW = $clog2(PROCESS_ENTRIES + 1);
   localparam int SIW = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
   localparam int SCW = $clog2(STREAM_ENTRIES + 1);
   localparam int NC  = sqc_pkg::NUM_COUNTERS;
   localparam int CW  = NC * COUNTER_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_PSCAN, ST_PREAD, ST_PCAP, ST_SSCAN, ST_UPDATE
   } state_type;

   state_type state_ff;
   sqc_pkg::cmd_type cmd_ff;

   logic [31:0]         pkey_mem [PROCESS_ENTRIES];
   logic [CW-1:0]       pcnt_mem [PROCESS_ENTRIES];
   sqc_pkg::stream_type smem     [STREAM_ENTRIES];

   logic [31:0]         pkey_rd_ff;
   logic [CW-1:0]       pcnt_rd_ff;
   sqc_pkg::stream_type sent_rd_ff;

   logic [PFW-1:0] fill_ff, pscan_ff;
   logic [PIW-1:0] ptag_ff, pslot_ff;
   logic           ptagv_ff;
   logic [SCW-1:0] sscan_ff;
   logic [SIW-1:0] stag_ff, sslot_ff, sfree_ff;
   logic           stagv_ff, sfree_v_ff, have_s_ff, proc_ok_ff;
   logic [COUNTER_BITS-1:0] cnt_ff [NC];
   sqc_pkg::stream_type ent_ff;
   logic           rsp_valid_ff;
   logic [255:0]   rsp_data_ff;
   logic [2:0]     rsp_user_ff;

   logic [COUNTER_BITS-1:0] upd_cnt [NC];
   sqc_pkg::stream_type upd_ent;
   logic [2:0]     upd_outcome;
   logic [255:0]   upd_data;
   logic [CW-1:0]  pcnt_wdata;
   logic           pkey_we, pcnt_we, smem_we, pmiss, phit, shit, send;
   logic           rsp_load;
   logic [SIW-1:0] smem_wa;
   sqc_pkg::stream_type smem_wd;
   logic [63:0]    key;

   assign key        = {cmd_ff.pid, cmd_ff.key_lo};
   assign cmd_pop_o  = (state_ff == ST_IDLE) && cmd_valid_i;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_load   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   assign phit  = ptagv_ff && (pkey_rd_ff == cmd_ff.pid);
   assign pmiss = !ptagv_ff && (pscan_ff >= fill_ff);
   assign shit  = stagv_ff && sent_rd_ff.used && (sent_rd_ff.key == key);
   assign send  = !stagv_ff && (sscan_ff == SCW'(STREAM_ENTRIES));

   assign pkey_we = (state_ff == ST_PSCAN) && !phit && pmiss &&
                    (fill_ff < PFW'(PROCESS_ENTRIES));
   assign pcnt_we = (state_ff == ST_UPDATE) && proc_ok_ff;

   always_comb begin
      smem_we = 1'b0;
      smem_wa = sslot_ff;
      smem_wd = upd_ent;
      if (state_ff == ST_CLEAR) begin
         smem_we = 1'b1;
         smem_wa = sscan_ff[SIW-1:0];
         smem_wd = '0;
      end else if (state_ff == ST_UPDATE) begin
         smem_we = have_s_ff && proc_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pkey_we) begin
         pkey_mem[fill_ff[PIW-1:0]] <= cmd_ff.pid;
      end
      pkey_rd_ff <= pkey_mem[pscan_ff[PIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pcnt_we) begin
         pcnt_mem[pslot_ff] <= pcnt_wdata;
      end
      pcnt_rd_ff <= pcnt_mem[pslot_ff];
   end

   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[smem_wa] <= smem_wd;
      end
      sent_rd_ff <= smem[sscan_ff[SIW-1:0]];
   end

   always_comb begin
      logic        rd, posd, ret_neg, do_cls, seq, ba, bb;
      logic [2:0]  ia, ib;
      logic [63:0] start, stop;
      rd      = (cmd_ff.op == sqc_pkg::OP_RD) || (cmd_ff.op == sqc_pkg::OP_POS_RD);
      posd    = (cmd_ff.op == sqc_pkg::OP_POS_RD) || (cmd_ff.op == sqc_pkg::OP_POS_WR);
      ret_neg = cmd_ff.ret[63];
      upd_ent = ent_ff;
      upd_outcome = sqc_pkg::OUT_BOOK;
      ba = 1'b0;
      bb = 1'b0;
      ia = rd ? sqc_pkg::CNT_RTOT : sqc_pkg::CNT_WTOT;
      ib = rd ? sqc_pkg::CNT_UR : sqc_pkg::CNT_UW;
      start  = '0;
      do_cls = 1'b0;
      case (cmd_ff.op)
         sqc_pkg::OP_RD, sqc_pkg::OP_WR, sqc_pkg::OP_POS_RD, sqc_pkg::OP_POS_WR: begin
            ba = 1'b1;
            if (!have_s_ff || ret_neg || (cmd_ff.ret == 64'd0)) begin
               bb = 1'b1;
               upd_outcome = sqc_pkg::OUT_UNCLS;
            end else if (posd) begin
               start  = cmd_ff.pos;
               do_cls = 1'b1;
               upd_ent.flags[sqc_pkg::F_NOSEEK] = 1'b0;
            end else if (ent_ff.flags[sqc_pkg::F_NOSEEK]) begin
               bb = 1'b1;
               upd_outcome = sqc_pkg::OUT_UNCLS;
            end else begin
               start  = ent_ff.flags[sqc_pkg::F_CURSOR] ? ent_ff.cursor : 64'd0;
               do_cls = 1'b1;
            end
         end
         sqc_pkg::OP_OPEN: begin
            if (!ret_neg) begin
               upd_ent.cursor = '0;
               upd_ent.flags[sqc_pkg::F_NOSEEK] = 1'b0;
               upd_ent.flags[sqc_pkg::F_CURSOR] = 1'b1;
            end
         end
         sqc_pkg::OP_SEEK: begin
            if (!ret_neg) begin
               upd_ent.cursor = cmd_ff.ret;
               upd_ent.flags[sqc_pkg::F_NOSEEK] = 1'b0;
               upd_ent.flags[sqc_pkg::F_CURSOR] = 1'b1;
            end else if (cmd_ff.ret == sqc_pkg::NO_SEEK_RET) begin
               upd_ent.flags[sqc_pkg::F_NOSEEK] = 1'b1;
               upd_ent.flags[sqc_pkg::F_CURSOR] = 1'b0;
            end
         end
         sqc_pkg::OP_SHUT: begin
            upd_ent.used = 1'b0;
         end
         default: begin
         end
      endcase
      seq  = !ent_ff.flags[sqc_pkg::F_LAST] || (start == ent_ff.end_pos);
      stop = start + cmd_ff.ret;
      if (do_cls) begin
         bb = 1'b1;
         if (rd) begin
            ib = seq ? sqc_pkg::CNT_SR : sqc_pkg::CNT_RR;
         end else begin
            ib = seq ? sqc_pkg::CNT_SW : sqc_pkg::CNT_RW;
         end
         upd_outcome = seq ? sqc_pkg::OUT_SEQ : sqc_pkg::OUT_RAND;
         upd_ent.end_pos = stop;
         upd_ent.cursor  = stop;
         upd_ent.flags[sqc_pkg::F_LAST]   = 1'b1;
         upd_ent.flags[sqc_pkg::F_CURSOR] = 1'b1;
      end
      if (!proc_ok_ff) begin
         upd_outcome = sqc_pkg::OUT_DROP;
      end
      for (int j = 0; j < NC; j++) begin
         upd_cnt[j] = cnt_ff[j] + COUNTER_BITS'(((ba && (ia == 3'(j))) ||
                      (bb && (ib == 3'(j)))) && (cnt_ff[j] != '1));
         pcnt_wdata[j*COUNTER_BITS +: COUNTER_BITS] = upd_cnt[j];
         upd_data[j*32 +: 32] = proc_ok_ff ? 32'(upd_cnt[j]) : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sscan_ff     <= '0;
         fill_ff      <= '0;
         ptagv_ff     <= 1'b0;
         stagv_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (sscan_ff == SCW'(STREAM_ENTRIES - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  sscan_ff <= sscan_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (cmd_valid_i) begin
                  cmd_ff   <= cmd_i;
                  pscan_ff <= '0;
                  ptagv_ff <= 1'b0;
                  state_ff <= ST_PSCAN;
               end
            end
            ST_PSCAN: begin
               if (phit) begin
                  pslot_ff <= ptag_ff;
                  ptagv_ff <= 1'b0;
                  state_ff <= ST_PREAD;
               end else if (pmiss) begin
                  if (fill_ff < PFW'(PROCESS_ENTRIES)) begin
                     pslot_ff   <= fill_ff[PIW-1:0];
                     fill_ff    <= fill_ff + 1'b1;
                     proc_ok_ff <= 1'b1;
                     for (int j = 0; j < NC; j++) begin
                        cnt_ff[j] <= '0;
                     end
                     sscan_ff   <= '0;
                     stagv_ff   <= 1'b0;
                     sfree_v_ff <= 1'b0;
                     have_s_ff  <= 1'b0;
                     state_ff   <= cmd_ff.need_stream ? ST_SSCAN : ST_UPDATE;
                  end else begin
                     proc_ok_ff <= 1'b0;
                     have_s_ff  <= 1'b0;
                     state_ff   <= ST_UPDATE;
                  end
               end else if (pscan_ff < fill_ff) begin
                  ptag_ff  <= pscan_ff[PIW-1:0];
                  ptagv_ff <= 1'b1;
                  pscan_ff <= pscan_ff + 1'b1;
               end else begin
                  ptagv_ff <= 1'b0;
               end
            end
            ST_PREAD: begin
               state_ff <= ST_PCAP;
            end
            ST_PCAP: begin
               for (int j = 0; j < NC; j++) begin
                  cnt_ff[j] <= pcnt_rd_ff[j*COUNTER_BITS +: COUNTER_BITS];
               end
               proc_ok_ff <= 1'b1;
               sscan_ff   <= '0;
               stagv_ff   <= 1'b0;
               sfree_v_ff <= 1'b0;
               have_s_ff  <= 1'b0;
               state_ff   <= cmd_ff.need_stream ? ST_SSCAN : ST_UPDATE;
            end
            ST_SSCAN: begin
               if (shit) begin
                  ent_ff    <= sent_rd_ff;
                  sslot_ff  <= stag_ff;
                  have_s_ff <= 1'b1;
                  stagv_ff  <= 1'b0;
                  state_ff  <= ST_UPDATE;
               end else if (send) begin
                  have_s_ff <= cmd_ff.may_create && sfree_v_ff;
                  sslot_ff  <= sfree_ff;
                  ent_ff    <= '{used: 1'b1, key: key, end_pos: '0, cursor: '0,
                                 flags: '0};
                  state_ff  <= ST_UPDATE;
               end else begin
                  if (stagv_ff && !sent_rd_ff.used && !sfree_v_ff) begin
                     sfree_v_ff <= 1'b1;
                     sfree_ff   <= stag_ff;
                  end
                  if (sscan_ff < SCW'(STREAM_ENTRIES)) begin
                     stag_ff  <= sscan_ff[SIW-1:0];
                     stagv_ff <= 1'b1;
                     sscan_ff <= sscan_ff + 1'b1;
                  end else begin
                     stagv_ff <= 1'b0;
                  end
               end
            end
            ST_UPDATE: begin
               if (rsp_load) begin
                  rsp_data_ff  <= upd_data;
                  rsp_user_ff  <= upd_outcome;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= PFW'(PROCESS_ENTRIES))
   `ASSERT_IMPLIES(a_drop_zero, clock, reset, rsp_valid_ff && (rsp_user_ff == sqc_pkg::OUT_DROP), rsp_data_ff == '0)
   `ASSERT_NEXT(a_update_load, clock, reset, (state_ff == ST_UPDATE) && !rsp_valid_ff, rsp_valid_ff)

endmodule
`default_nettype wire

// ----- sv/io_stream_sequentiality_classifier.sv -----
// The engine scans the process memory over the process entries in use (one key compare a
// cycle), then the stream memory (one stream entry compare a cycle); open with an error, close
// with a nonzero result and the unused code skip the stream scan. A two-word input queue keeps
// accepting, until it is full, while the engine works or a result waits. Reset is synchronous;
// afterwards a clearing pass writes every stream entry to zero before the first word is processed.
`timescale 1ns / 1ps
`default_nettype none
module io_stream_sequentiality_classifier #(
   parameter int PROCESS_ENTRIES = sqc_pkg::PROCESS_ENTRIES,
   parameter int STREAM_ENTRIES  = sqc_pkg::STREAM_ENTRIES,
   parameter int COUNTER_BITS    = sqc_pkg::COUNTER_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [191:0] req_tdata,  // process_id, file_handle, explicit_offset, call_result
   input  wire logic [2:0]   req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [255:0]      rsp_tdata,  // read_total, write_total, seq_read_count,
                                         // rand_read_count, seq_write_count,
                                         // rand_write_count, uncls_read_count,
                                         // uncls_write_count
   output logic [2:0]        rsp_tuser   // outcome
);

   sqc_pkg::push_type push;
   sqc_pkg::cmd_type  cmd;
   logic              full, cmd_valid, cmd_pop;

   sqc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .full_i     (full),
      .push_o     (push)
   );

   sqc_queue #(
      .DEPTH (sqc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .full_o  (full),
      .valid_o (cmd_valid),
      .cmd_o   (cmd),
      .pop_i   (cmd_pop)
   );

   sqc_engine #(
      .PROCESS_ENTRIES (PROCESS_ENTRIES),
      .STREAM_ENTRIES  (STREAM_ENTRIES),
      .COUNTER_BITS    (COUNTER_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid_i (cmd_valid),
      .cmd_i       (cmd),
      .cmd_pop_o   (cmd_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire
